// ----- hdl/stq_pkg.sv -----
// Shared types and constants for the sorted timer queue.
// Holds the command and result transaction structs, the operation codes and the
// sequencer states. It depends on nothing else.
`default_nettype none

package stq_pkg;

  // default sizing handed to the top level
  localparam int MAX_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // fixed field widths of the command and result transactions
  localparam int ID_W      = 4;
  localparam int TIMEOUT_W = 32;
  localparam int NUM_SLOTS = 1 << ID_W;

  // a poll pops at most this many expired entries
  localparam int POLL_LIMIT = 16;
  localparam int BUF_AW     = $clog2(POLL_LIMIT);
  localparam int PC_W       = BUF_AW + 1;

  // operation codes
  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_RESTART = 3'd1,
    OP_STOP    = 3'd2,
    OP_TICK    = 3'd3,
    OP_POLL    = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_RM_RD,
    S_RM_CHK,
    S_SD_RD,
    S_SD_WR,
    S_FP_RD,
    S_FP_CHK,
    S_SU_RD,
    S_SU_WR,
    S_TK_RD,
    S_TK_WR,
    S_PL_RD,
    S_PL_CHK,
    S_HD_RD,
    S_HD_CAP,
    S_EMIT
  } state_t;

  // command transaction
  typedef struct packed {
    logic [2:0]           operation;
    logic [ID_W-1:0]      timer_id;
    logic [TIMEOUT_W-1:0] timeout;
    logic [TIMEOUT_W-1:0] elapsed;
    logic                 handler_present;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic                 expired_valid;
    logic [ID_W-1:0]      expired_id;
    logic                 handler_fired;
    logic                 last;
    logic                 pending;
    logic [TIMEOUT_W-1:0] next_timeout;
    logic                 poll_request;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/stq_alu.sv -----
// Shared subtract and compare unit of the sorted timer queue.
// Gives the saturating difference a - b and the a >= b flag; uses stq_pkg for defaults.
`default_nettype none

module stq_alu
  import stq_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic [TIME_BITS-1:0] a,
  input  wire logic [TIME_BITS-1:0] b,
  output logic      [TIME_BITS-1:0] sat_diff,
  output logic                      a_ge_b
);

  logic [TIME_BITS:0] diff_full;

  // one wide subtract, borrow decides both outputs
  assign diff_full = {1'b0, a} - {1'b0, b};
  assign a_ge_b    = ~diff_full[TIME_BITS];
  assign sat_diff  = diff_full[TIME_BITS] ? '0 : diff_full[TIME_BITS-1:0];

endmodule

`default_nettype wire

// ----- hdl/sorted_timer_queue_unit.sv -----
// Sorted timer queue: top level with the sequencer, the entry memory and result output.
// Depends on stq_pkg for types and codes and on stq_alu for the shared subtract/compare.
//
// Timer slots wait in an entry memory kept sorted by remaining ticks, one entry per word
// with one read and one write port. Commands walk that memory under a small sequencer
// that reads one word per step and writes one back where an entry moves or changes.
// Start and restart find and drop any old copy, then find the spot for the new time,
// open a gap there from the tail down and place the entry; stop finds and drops the
// slot; tick rewrites every entry; poll scans the expired entries from the head and
// then compacts the queue when it found any. Every command then reads the head entry
// (skipped when the queue is empty) and sends its results. Results leave on
// out_valid/out_item, one per cycle, each present for exactly one cycle with no way
// for the receiver to stall them; a poll gives one result per expired slot, the last
// one marked, or a single empty result. busy stays high from the accepted command
// until its final result is on the ports.
`default_nettype none

module sorted_timer_queue_unit
  import stq_pkg::*;
#(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int LEN_W = $clog2(MAX_TIMERS + 1);
  localparam int AW    = $clog2(MAX_TIMERS);
  localparam int ENT_W = ID_W + TIME_BITS;

  // sequencer and queue control registers
  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [TIME_BITS-1:0] opnd_r, opnd_nxt;
  logic                 ins_r, ins_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     idx_r, idx_nxt;
  logic [LEN_W-1:0]     pos_r, pos_nxt;
  logic [LEN_W-1:0]     dist_r, dist_nxt;
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic [PC_W-1:0]      em_r, em_nxt;
  logic [TIME_BITS-1:0] head_r, head_nxt;
  logic [NUM_SLOTS-1:0] hnd_r, hnd_nxt;
  logic [ID_W-1:0]      buf_r [POLL_LIMIT];
  logic [ID_W-1:0]      buf_nxt [POLL_LIMIT];
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  // entry memory
  logic [ENT_W-1:0]     mem [MAX_TIMERS];
  logic [ENT_W-1:0]     rd_q;
  logic [AW-1:0]        mem_ra;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [ENT_W-1:0]     mem_wd;

  // fields of the word read last cycle
  logic [TIME_BITS-1:0] rd_rem;
  logic [ID_W-1:0]      rd_id;
  logic [TIME_BITS-1:0] sat_diff;
  logic                 a_ge_b;

  assign rd_rem = rd_q[TIME_BITS-1:0];
  assign rd_id  = rd_q[ENT_W-1 -: ID_W];

  // shared subtract/compare: tick saturation and insertion position search
  stq_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .a        (rd_rem),
    .b        (opnd_r),
    .sat_diff (sat_diff),
    .a_ge_b   (a_ge_b)
  );

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      hnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      hnd_r       <= hnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    opnd_r     <= opnd_nxt;
    ins_r      <= ins_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    dist_r     <= dist_nxt;
    pc_r       <= pc_nxt;
    em_r       <= em_nxt;
    head_r     <= head_nxt;
    buf_r      <= buf_nxt;
    out_item_r <= out_item_nxt;
  end

  // sequencer: next state, memory controls and results
  always_comb begin
    logic [LEN_W:0]       src;
    logic [LEN_W-1:0]     len_left;
    logic                 id_ok;
    logic [TIME_BITS-1:0] tmo;
    logic [ID_W-1:0]      pop_id;

    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    opnd_nxt      = opnd_r;
    ins_nxt       = ins_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    dist_nxt      = dist_r;
    pc_nxt        = pc_r;
    em_nxt        = em_r;
    head_nxt      = head_r;
    hnd_nxt       = hnd_r;
    buf_nxt       = buf_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_ra        = '0;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;

    src      = {1'b0, idx_r} + {1'b0, dist_r};
    len_left = len_r - dist_r;
    id_ok    = 32'(in_item.timer_id) < 32'(MAX_TIMERS);
    tmo      = TIME_BITS'(in_item.timeout);
    pop_id   = buf_r[em_r[BUF_AW-1:0]];

    case (state_r)
      // accept a command transaction and dispatch on the operation
      S_IDLE: begin
        if (start) begin
          op_nxt  = op_t'(in_item.operation);
          id_nxt  = in_item.timer_id;
          idx_nxt = '0;
          pc_nxt  = '0;
          em_nxt  = '0;
          ins_nxt = 1'b0;
          state_nxt = S_HD_RD;
          case (in_item.operation)
            OP_START: begin
              if (id_ok && (tmo != '0) && in_item.handler_present) begin
                hnd_nxt[in_item.timer_id] = 1'b1;
                opnd_nxt  = tmo;
                ins_nxt   = 1'b1;
                state_nxt = S_RM_RD;
              end
            end
            OP_RESTART: begin
              if (id_ok) begin
                opnd_nxt  = tmo;
                ins_nxt   = 1'b1;
                state_nxt = S_RM_RD;
              end
            end
            OP_STOP: begin
              if (id_ok) begin
                hnd_nxt[in_item.timer_id] = 1'b0;
                state_nxt = S_RM_RD;
              end
            end
            OP_TICK: begin
              opnd_nxt  = TIME_BITS'(in_item.elapsed);
              state_nxt = S_TK_RD;
            end
            OP_POLL: begin
              state_nxt = S_PL_RD;
            end
            OP_CLEAR: begin
              len_nxt = '0;
            end
            default: begin
              state_nxt = S_HD_RD;
            end
          endcase
        end
      end

      // search the queue for the addressed slot
      S_RM_RD: begin
        if (idx_r == len_r) begin
          idx_nxt = '0;
          if (ins_r && (32'(len_r) < 32'(MAX_TIMERS))) begin
            state_nxt = S_FP_RD;
          end else begin
            state_nxt = S_HD_RD;
          end
        end else begin
          mem_ra    = idx_r[AW-1:0];
          state_nxt = S_RM_CHK;
        end
      end

      S_RM_CHK: begin
        if (rd_id == id_r) begin
          dist_nxt  = LEN_W'(1);
          state_nxt = S_SD_RD;
        end else begin
          idx_nxt   = idx_r + LEN_W'(1);
          state_nxt = S_RM_RD;
        end
      end

      // close a gap of dist entries starting at idx
      S_SD_RD: begin
        if (src >= {1'b0, len_r}) begin
          len_nxt = len_left;
          idx_nxt = '0;
          if (ins_r && (32'(len_left) < 32'(MAX_TIMERS))) begin
            state_nxt = S_FP_RD;
          end else begin
            state_nxt = S_HD_RD;
          end
        end else begin
          mem_ra    = src[AW-1:0];
          state_nxt = S_SD_WR;
        end
      end

      S_SD_WR: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r[AW-1:0];
        mem_wd    = rd_q;
        idx_nxt   = idx_r + LEN_W'(1);
        state_nxt = S_SD_RD;
      end

      // find the first entry not below the new time
      S_FP_RD: begin
        if (idx_r == len_r) begin
          pos_nxt   = len_r;
          state_nxt = S_SU_RD;
        end else begin
          mem_ra    = idx_r[AW-1:0];
          state_nxt = S_FP_CHK;
        end
      end

      S_FP_CHK: begin
        if (a_ge_b) begin
          pos_nxt   = idx_r;
          idx_nxt   = len_r;
          state_nxt = S_SU_RD;
        end else begin
          idx_nxt   = idx_r + LEN_W'(1);
          state_nxt = S_FP_RD;
        end
      end

      // open a gap at pos from the tail down, then place the entry
      S_SU_RD: begin
        if (idx_r == pos_r) begin
          mem_we    = 1'b1;
          mem_wa    = pos_r[AW-1:0];
          mem_wd    = {id_r, opnd_r};
          len_nxt   = len_r + LEN_W'(1);
          state_nxt = S_HD_RD;
        end else begin
          mem_ra    = idx_r[AW-1:0] - AW'(1);
          state_nxt = S_SU_WR;
        end
      end

      S_SU_WR: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r[AW-1:0];
        mem_wd    = rd_q;
        idx_nxt   = idx_r - LEN_W'(1);
        state_nxt = S_SU_RD;
      end

      // saturating subtract of the elapsed ticks from each entry
      S_TK_RD: begin
        if (idx_r == len_r) begin
          state_nxt = S_HD_RD;
        end else begin
          mem_ra    = idx_r[AW-1:0];
          state_nxt = S_TK_WR;
        end
      end

      S_TK_WR: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r[AW-1:0];
        mem_wd    = {rd_id, sat_diff};
        idx_nxt   = idx_r + LEN_W'(1);
        state_nxt = S_TK_RD;
      end

      // collect expired entries from the head
      S_PL_RD: begin
        if ((idx_r == len_r) || (32'(pc_r) == POLL_LIMIT)) begin
          dist_nxt  = idx_r;
          idx_nxt   = '0;
          state_nxt = (pc_r == '0) ? S_HD_RD : S_SD_RD;
        end else begin
          mem_ra    = idx_r[AW-1:0];
          state_nxt = S_PL_CHK;
        end
      end

      S_PL_CHK: begin
        if (rd_rem == '0) begin
          buf_nxt[pc_r[BUF_AW-1:0]] = rd_id;
          pc_nxt    = pc_r + PC_W'(1);
          idx_nxt   = idx_r + LEN_W'(1);
          state_nxt = S_PL_RD;
        end else begin
          dist_nxt  = idx_r;
          idx_nxt   = '0;
          state_nxt = (pc_r == '0) ? S_HD_RD : S_SD_RD;
        end
      end

      // fetch the head entry for the status fields
      S_HD_RD: begin
        if (len_r == '0) begin
          head_nxt  = '0;
          state_nxt = S_EMIT;
        end else begin
          mem_ra    = '0;
          state_nxt = S_HD_CAP;
        end
      end

      S_HD_CAP: begin
        head_nxt  = rd_rem;
        state_nxt = S_EMIT;
      end

      // send one result transaction per cycle
      S_EMIT: begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.pending       = (len_r != '0);
        out_item_nxt.next_timeout  = TIMEOUT_W'(head_r);
        out_item_nxt.poll_request  = (op_r == OP_TICK) && (len_r != '0) && (head_r == '0);
        if (pc_r == '0) begin
          out_item_nxt.expired_valid = 1'b0;
          out_item_nxt.expired_id    = '0;
          out_item_nxt.handler_fired = 1'b0;
          out_item_nxt.last          = 1'b1;
          state_nxt                  = S_IDLE;
        end else begin
          out_item_nxt.expired_valid = 1'b1;
          out_item_nxt.expired_id    = pop_id;
          out_item_nxt.handler_fired = hnd_r[pop_id];
          out_item_nxt.last          = (em_r == pc_r - PC_W'(1));
          em_nxt                     = em_r + PC_W'(1);
          if (em_r == pc_r - PC_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // an accepted command keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepted command");

  // the queue never holds more entries than slots
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= 32'(MAX_TIMERS))
    else $error("queue length beyond capacity");

  // results of one command leave back to back
  a_results_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid)
    else $error("gap inside a result burst");

  // pending follows the final queue length
  a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.pending == (len_r != '0)))
    else $error("pending disagrees with queue length");

  // a poll request means a queued head at zero
  a_poll_req_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.poll_request |-> out_item.pending && (head_r == '0))
    else $error("poll request without an expired head");
`endif

endmodule

`default_nettype wire
